[hw/rtl/welford_vec3_stats_with_histogram_defines.svh]
// assertion macros for the welford statistics rtl
// no dependencies
`ifndef WELFORD_VEC3_STATS_WITH_HISTOGRAM_DEFINES_SVH
`define WELFORD_VEC3_STATS_WITH_HISTOGRAM_DEFINES_SVH

// implication checked on every clock edge outside reset
`define WVS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define WVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wvs_pkg.sv]
// types and constants for the welford statistics block
// no dependencies
package wvs_pkg;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned OUT_W    = 63;
  localparam int unsigned BIN_W    = 32;
  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 352;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_READ, ST_MEAN_DIV, ST_MEAN_UPD, ST_MUL,
    ST_ACC, ST_VAR_DIV, ST_VAR_SAT, ST_WRITE, ST_OUT
  } wvs_state_t;
endpackage

[hw/rtl/wvs_ram.sv]
// generic single-port ram with registered read
// no dependencies
module wvs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[hw/rtl/wvs_div.sv]
// restoring divider, one quotient bit per cycle, DW-bit dividend (64 by default)
// depends on wvs_pkg
module wvs_div
  import wvs_pkg::*;
#(
  parameter int unsigned DW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DW-1:0], q_r[DW-1]};
    diff     = trial - {1'b0, d_r};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff;
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

[hw/rtl/welford_vec3_stats_with_histogram.sv]
// top level of the welford mean/variance block with step histogram
// depends on wvs_pkg, wvs_ram, wvs_div and the defines header
//
// One transaction in, one transaction out. The block accepts a sample,
// runs a sequencer over three components, and returns count, means,
// variances and the histogram bin total. Per component the sequencer
// does a 64-step division for the mean update and another for the
// variance on the shared bit-serial divider. Each component passes the
// read, update, multiply, accumulate and saturate states, and one
// write-back and one output state close the pass; a dropped sample
// skips the mean divisions and the first sample skips the variance
// divisions. in_tready comes back when the sequencer returns to idle,
// so a new sample is not taken before the last one is through. The
// result waits in an output register, so the next transaction is taken
// while it waits; the sequencer holds before presenting a new result until
// the old one has left. After reset a clearing pass walks the histogram
// and component memories, one word a cycle over max(HIST_BINS, 4) words,
// with in_tready low. Means and squared-deviation sums sit in a small
// memory of four words (one per component, the last unused), histogram
// bins in another.
`include "welford_vec3_stats_with_histogram_defines.svh"
module welford_vec3_stats_with_histogram
  import wvs_pkg::*;
#(
  parameter int unsigned HIST_BINS   = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // sample_x, sample_y, sample_z, step_count
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // total_samples, mean_x, mean_y, mean_z, var_x, var_y, var_z,
  // var_valid, bin_total, sample_taken, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata
);
  localparam int unsigned BA = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
  // clearing pass covers both the bins and the four component words
  localparam int unsigned CLR_N  = (HIST_BINS > 4) ? HIST_BINS : 4;
  localparam int unsigned CLR_AW = $clog2(CLR_N);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  wvs_state_t state_r, state_nxt;

  // captured input
  logic [SAMPLE_W-1:0] smp_r [3];
  logic [BA-1:0]       bin_r;
  logic                taken_r;
  logic [1:0]          k_r;
  logic [CLR_AW-1:0]   clr_r;
  logic [COUNT_WIDTH-1:0] cnt_r;

  // working registers
  logic signed [SAMPLE_W-1:0] mean_r;
  logic [ACC_W-1:0]           m2_r;
  logic signed [SAMPLE_W:0]   delta_r;
  logic [ACC_W-1:0]           prod_r;
  logic [OUT_W-1:0]           var_r [3];
  logic signed [SAMPLE_W-1:0] mout_r [3];
  logic [BIN_W-1:0]           bin_tot_r;
  logic [OUT_TDATA_W-1:0]     out_r;
  logic                       outv_r;

  // component memory: {mean, m2}
  logic                    cm_we;
  logic [1:0]              cm_addr;
  logic [SAMPLE_W+ACC_W-1:0] cm_wdata, cm_rdata;
  // histogram memory
  logic           hm_we;
  logic [BA-1:0]  hm_addr;
  logic [BIN_W-1:0] hm_wdata, hm_rdata;

  logic           div_start;
  logic [ACC_W-1:0] div_a, div_b, div_q;
  logic           div_done;
  logic           did_var_r;

  wvs_ram #(.WIDTH(SAMPLE_W + ACC_W), .DEPTH(4)) u_cmem (
    .clk(clk), .we(cm_we), .addr(cm_addr), .wdata(cm_wdata), .rdata(cm_rdata)
  );
  wvs_ram #(.WIDTH(BIN_W), .DEPTH(1 << BA)) u_hmem (
    .clk(clk), .we(hm_we), .addr(hm_addr), .wdata(hm_wdata), .rdata(hm_rdata)
  );
  wvs_div #(.DW(ACC_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  // input unpack and bin clamp
  logic [15:0]   steps_in;
  logic [BA-1:0] bin_in;
  assign steps_in = in_tdata[111:96];
  always_comb begin
    if (32'(steps_in) >= 32'(HIST_BINS - 1)) begin
      bin_in = BA'(HIST_BINS - 1);
    end else begin
      bin_in = BA'(steps_in);
    end
  end

  logic in_acc;
  logic out_free;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  // output register empty or emptying this cycle
  assign out_free  = !outv_r || out_tready;

  // datapath helpers
  logic signed [SAMPLE_W:0] x_ext, delta2_c;
  logic [SAMPLE_W:0]        mag_d, mag_d2;
  logic signed [SAMPLE_W:0] mean_new;
  logic [ACC_W:0]           sum_c;
  logic [ACC_W-1:0]         m2_sat;
  logic [COUNT_WIDTH-1:0]   cnt_m1;
  logic                     vvalid;

  always_comb begin
    x_ext    = {smp_r[k_r][SAMPLE_W-1], smp_r[k_r]};
    mag_d    = delta_r[SAMPLE_W] ? (SAMPLE_W+1)'(-delta_r) : delta_r;
    mean_new = delta_r[SAMPLE_W] ?
               ({mean_r[SAMPLE_W-1], mean_r} - (SAMPLE_W+1)'(div_q)) :
               ({mean_r[SAMPLE_W-1], mean_r} + (SAMPLE_W+1)'(div_q));
    delta2_c = x_ext - {mean_r[SAMPLE_W-1], mean_r};
    mag_d2   = delta2_c[SAMPLE_W] ? (SAMPLE_W+1)'(-delta2_c) : delta2_c;
    sum_c    = {1'b0, m2_r} + {1'b0, prod_r};
    m2_sat   = sum_c[ACC_W] ? '1 : sum_c[ACC_W-1:0];
    cnt_m1   = cnt_r - 1'b1;
    vvalid   = cnt_r >= COUNT_WIDTH'(2);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (clr_r == CLR_AW'(CLR_N - 1))
                     state_nxt = ST_IDLE;
                   else state_nxt = ST_CLEAR;
      ST_IDLE:     if (in_acc) state_nxt = ST_READ;
      ST_READ:     state_nxt = taken_r ? ST_MEAN_DIV : ST_VAR_DIV;
      ST_MEAN_DIV: if (div_done) state_nxt = ST_MEAN_UPD;
      ST_MEAN_UPD: state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_ACC;
      ST_ACC:      state_nxt = ST_VAR_DIV;
      ST_VAR_DIV:  if (!vvalid || (did_var_r && div_done)) state_nxt = ST_VAR_SAT;
      ST_VAR_SAT:  state_nxt = (k_r == 2'd2) ? ST_WRITE : ST_READ;
      ST_WRITE:    state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    cm_we     = 1'b0;
    cm_addr   = k_r;
    cm_wdata  = {mean_r, m2_sat};
    hm_we     = 1'b0;
    hm_addr   = bin_r;
    hm_wdata  = bin_tot_r;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (state_r)
      ST_CLEAR: begin
        hm_we    = 1'b1;
        hm_addr  = clr_r[BA-1:0];
        hm_wdata = '0;
        cm_we    = 1'b1;
        cm_addr  = clr_r[1:0];
        cm_wdata = '0;
      end
      ST_IDLE: begin
        hm_addr = bin_in;
        cm_addr = 2'd0;
      end
      ST_MEAN_DIV: begin
        div_start = !did_var_r;
        div_a     = ACC_W'(mag_d);
        div_b     = ACC_W'(cnt_r);
      end
      // write back the updated mean and saturated sum
      ST_ACC: begin
        cm_we = taken_r;
      end
      ST_VAR_DIV: begin
        div_start = vvalid && !did_var_r;
        div_a     = m2_r;
        div_b     = ACC_W'(cnt_m1);
      end
      // fetch the next component for the following read cycle
      ST_VAR_SAT: begin
        cm_addr = k_r + 2'd1;
      end
      ST_WRITE: begin
        hm_we = taken_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      cnt_r     <= '0;
      outv_r    <= 1'b0;
      did_var_r <= 1'b0;
      k_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == ST_OUT && out_free) outv_r <= 1'b1;
      else if (out_tvalid && out_tready) outv_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          k_r       <= '0;
          did_var_r <= 1'b0;
          if (in_acc && cnt_r != CNT_MAX) cnt_r <= cnt_r + 1'b1;
        end
        ST_MEAN_DIV: did_var_r <= !div_done;
        ST_VAR_DIV:  did_var_r <= !div_done;
        ST_VAR_SAT: begin
          k_r       <= k_r + 1'b1;
          did_var_r <= 1'b0;
        end
        default:     did_var_r <= 1'b0;
      endcase
    end
    // payload, no reset
    case (state_r)
      ST_IDLE: if (in_acc) begin
        smp_r[0] <= in_tdata[31:0];
        smp_r[1] <= in_tdata[63:32];
        smp_r[2] <= in_tdata[95:64];
        bin_r    <= bin_in;
        taken_r  <= cnt_r != CNT_MAX;
      end
      ST_READ: begin
        mean_r  <= cm_rdata[SAMPLE_W+ACC_W-1:ACC_W];
        m2_r    <= cm_rdata[ACC_W-1:0];
        delta_r <= {smp_r[k_r][SAMPLE_W-1], smp_r[k_r]} -
                   {cm_rdata[SAMPLE_W+ACC_W-1], cm_rdata[SAMPLE_W+ACC_W-1:ACC_W]};
        // bin count saturates at all ones
        if (k_r == 2'd0) begin
          if (taken_r && hm_rdata != '1) bin_tot_r <= hm_rdata + 1'b1;
          else bin_tot_r <= hm_rdata;
        end
      end
      ST_MEAN_UPD: mean_r <= SAMPLE_W'(mean_new);
      ST_MUL:      prod_r <= ACC_W'((ACC_W+2)'(mag_d) * (ACC_W+2)'(mag_d2)) >> 16;
      ST_ACC:      m2_r   <= m2_sat;
      ST_VAR_SAT: begin
        mout_r[k_r] <= mean_r;
        if (!vvalid) var_r[k_r] <= '0;
        else if (div_q[ACC_W-1]) var_r[k_r] <= '1;
        else var_r[k_r] <= div_q[OUT_W-1:0];
      end
      ST_OUT: if (out_free) begin
        out_r <= OUT_TDATA_W'({taken_r, bin_tot_r, vvalid, var_r[2], var_r[1],
                 var_r[0], mout_r[2], mout_r[1], mout_r[0], 32'(cnt_r)});
      end
      default: ;
    endcase
  end

  assign out_tvalid = outv_r;
  assign out_tdata  = out_r;

  `WVS_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, !in_tready,
    "input accepted while busy")
  `WVS_ASSERT_NEXT(a_out_after_seq, clk, rst_n, state_r == ST_OUT, out_tvalid,
    "result not presented")
  `WVS_ASSERT_IMPL(a_k_range, clk, rst_n, state_r == ST_VAR_SAT, k_r != 2'd3,
    "component index out of range")
endmodule
